// File: design/fdf_pkg.sv
// ----------------------------------------------------------------------------
// fdf_pkg: shared types and constants of the decimating FIR filter
// Fixed widths of the sample, coefficient, product and accumulator paths,
// and the item kind codes.
// ----------------------------------------------------------------------------
package fdf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_IDX_W = 5;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 40;
    localparam int FRAC_W     = 15;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [COEF_IDX_W-1:0] coef_idx_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    localparam acc_t    ROUND_HALF = acc_t'(1) <<< (FRAC_W - 1);
    localparam sample_t SAT_MAX    = sample_t'(16'sh7fff);
    localparam sample_t SAT_MIN    = sample_t'(16'sh8000);

endpackage

// File: design/fdf_if.sv
// ----------------------------------------------------------------------------
// fdf_if: valid/ready channels of the decimating FIR filter
// Input channel carries sample and coefficient items, output channel carries
// filtered samples.
// ----------------------------------------------------------------------------
interface fdf_in_if
    import fdf_pkg::*;
    ();

    logic      valid;
    logic      ready;
    logic      func;
    sample_t   sample_in;
    coef_idx_t coef_index;
    sample_t   coef_value;

    modport source (
        output valid,
        output func,
        output sample_in,
        output coef_index,
        output coef_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  sample_in,
        input  coef_index,
        input  coef_value,
        output ready
    );

endinterface

interface fdf_out_if
    import fdf_pkg::*;
    ();

    logic    valid;
    logic    ready;
    sample_t sample_out;

    modport source (
        output valid,
        output sample_out,
        input  ready
    );

    modport sink (
        input  valid,
        input  sample_out,
        output ready
    );

endinterface

// File: design/fir_decimate_by_four.sv
// ----------------------------------------------------------------------------
// fir_decimate_by_four: FIR low-pass filter with decimation
//
//   channel   dir   payload                                    transfer
//   samples   in    func, sample_in, coef_index, coef_value    valid & ready
//   results   out   sample_out                                 valid & ready
//
// A coefficient item or a dropped-phase sample is absorbed in the idle state. A kept
// sample runs TAPS passes of the single multiply-accumulate unit over the rotating
// delay and coefficient rings, then a drain state and a rounding state.
// samples.ready is low meanwhile.
// The result register holds a finished sample while results is stalled; the
// rounding cycle waits only when that register is still full.
// Reset clears the delay line, the coefficients and the decimation phase.
// ----------------------------------------------------------------------------
module fir_decimate_by_four
    import fdf_pkg::*;
#(
    parameter int TAPS       = 31,
    parameter int DECIMATION = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    fdf_in_if.sink   samples,
    fdf_out_if.source results
);

    localparam int CNT_W   = $clog2(TAPS);
    localparam int PHASE_W = $clog2(DECIMATION);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_ROUND = 2'd3;

    logic [1:0]         state_reg,  state_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [PHASE_W-1:0] phase_reg,  phase_next;
    sample_t            delay_reg [TAPS];
    sample_t            delay_next[TAPS];
    sample_t            coef_reg  [TAPS];
    sample_t            coef_next [TAPS];
    prod_t              prod_reg,   prod_next;
    logic               prod_valid_reg, prod_valid_next;
    acc_t               acc_reg,    acc_next;
    logic               out_valid_reg, out_valid_next;
    sample_t            out_data_reg,  out_data_next;

    logic               in_xfer;
    logic [31:0]        coef_idx_ext;
    acc_t               rnd_sum;
    logic               rnd_all_ones;
    logic               rnd_all_zeros;
    sample_t            rnd_sat;

    assign samples.ready      = (state_reg == ST_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.sample_out = out_data_reg;

    assign in_xfer      = samples.valid && samples.ready;
    assign coef_idx_ext = 32'(samples.coef_index);

    assign rnd_sum       = acc_reg + ROUND_HALF;
    assign rnd_all_ones  = &rnd_sum[ACC_W-1:FRAC_W+SAMPLE_W-1];
    assign rnd_all_zeros = ~|rnd_sum[ACC_W-1:FRAC_W+SAMPLE_W-1];

    always_comb
    begin
        if (rnd_sum[ACC_W-1] && !rnd_all_ones)
        begin
            rnd_sat = SAT_MIN;
        end
        else if (!rnd_sum[ACC_W-1] && !rnd_all_zeros)
        begin
            rnd_sat = SAT_MAX;
        end
        else
        begin
            rnd_sat = rnd_sum[FRAC_W+SAMPLE_W-1:FRAC_W];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        phase_next      = phase_reg;
        delay_next      = delay_reg;
        coef_next       = coef_reg;
        prod_next       = prod_reg;
        prod_valid_next = prod_valid_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (results.valid && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (prod_valid_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (samples.func == FUNC_COEF)
                    begin
                        if (coef_idx_ext < 32'(TAPS))
                        begin
                            for (int i = 0; i < TAPS; i++)
                            begin
                                if (coef_idx_ext == 32'(i))
                                begin
                                    coef_next[i] = samples.coef_value;
                                end
                            end
                        end
                    end
                    else
                    begin
                        for (int i = TAPS - 1; i > 0; i--)
                        begin
                            delay_next[i] = delay_reg[i-1];
                        end
                        delay_next[0] = samples.sample_in;

                        if (phase_reg == PHASE_W'(DECIMATION - 1))
                        begin
                            phase_next = '0;
                        end
                        else
                        begin
                            phase_next = phase_reg + PHASE_W'(1);
                        end

                        if (phase_reg == '0)
                        begin
                            acc_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_MAC;
                        end
                    end
                end
            end
            ST_MAC:
            begin
                prod_next       = delay_reg[0] * coef_reg[0];
                prod_valid_next = 1'b1;
                for (int i = 0; i < TAPS - 1; i++)
                begin
                    delay_next[i] = delay_reg[i+1];
                    coef_next[i]  = coef_reg[i+1];
                end
                delay_next[TAPS-1] = delay_reg[0];
                coef_next[TAPS-1]  = coef_reg[0];
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TAPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                prod_valid_next = 1'b0;
                state_next      = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_data_next  = rnd_sat;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            phase_reg      <= '0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < TAPS; i++)
            begin
                delay_reg[i] <= '0;
                coef_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            phase_reg      <= phase_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
            delay_reg      <= delay_next;
            coef_reg       <= coef_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

endmodule
